>>> sv/ocwc_pkg.sv
package ocwc_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int WHEELS        = 4;
   localparam int NUM_W         = 64;
   localparam int DIV_QB        = 32;
   // magnitude stage, prep stage, one stage per quotient bit, output stage
   localparam int DIV_LAT       = DIV_QB + 3;
   localparam int DEN_W         = 31;
   localparam int TSH_DEN_W     = DEN_W + 2;
   localparam int CSR_IDX_W     = 3;
   // quotient widths: saturated to 32 bits, or wide enough to keep a full 32-bit magnitude
   localparam int QUOT_W        = 32;
   localparam int FQ_W          = DIV_QB + 2;

   localparam logic [CSR_IDX_W-1:0] REG_WHEEL_RADIUS     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_DISTANCE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_ERROR_GAIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FRICTION_THRESH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FRICTION_A       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_FRICTION_B       = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_FRICTION_C       = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_FRICTION_D       = 3'd7;

   localparam logic [DEN_W-1:0] RADIUS_RST = 31'd5046;
   localparam logic [DEN_W-1:0] DIST_RST   = 31'd13107;
   localparam logic [DEN_W-1:0] GAIN_RST   = 31'd0;
   localparam logic [DEN_W-1:0] THRESH_RST = 31'd6554;

   // cos(pi/4) and sqrt(1/8) at 32 fraction bits
   localparam logic [63:0] COS45_Q32 = 64'd3037000500;
   localparam logic [63:0] RT8_Q32   = 64'd1518500250;

   function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
      logic signed [31:0] r;
      if (v > 65'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -65'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

>>> sv/ocwc_if.sv
interface ocwc_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] goal_vel_x;
   logic signed [31:0] goal_vel_y;
   logic signed [31:0] goal_yaw_rate;
   logic signed [31:0] demand_force_x;
   logic signed [31:0] demand_force_y;
   logic signed [31:0] demand_torque;
   logic signed [31:0] meas_speed_a;
   logic signed [31:0] meas_speed_b;
   logic signed [31:0] meas_speed_c;
   logic signed [31:0] meas_speed_d;
   modport source (output valid, goal_vel_x, goal_vel_y, goal_yaw_rate, demand_force_x,
                   demand_force_y, demand_torque, meas_speed_a, meas_speed_b,
                   meas_speed_c, meas_speed_d, input ready);
   modport sink (input valid, goal_vel_x, goal_vel_y, goal_yaw_rate, demand_force_x,
                 demand_force_y, demand_torque, meas_speed_a, meas_speed_b,
                 meas_speed_c, meas_speed_d, output ready);
endinterface

interface ocwc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] drive_current_a;
   logic signed [31:0] drive_current_b;
   logic signed [31:0] drive_current_c;
   logic signed [31:0] drive_current_d;
   logic signed [31:0] wheel_goal_speed_a;
   logic signed [31:0] wheel_goal_speed_b;
   logic signed [31:0] wheel_goal_speed_c;
   logic signed [31:0] wheel_goal_speed_d;
   modport source (output valid, drive_current_a, drive_current_b, drive_current_c,
                   drive_current_d, wheel_goal_speed_a, wheel_goal_speed_b,
                   wheel_goal_speed_c, wheel_goal_speed_d, input ready);
   modport sink (input valid, drive_current_a, drive_current_b, drive_current_c,
                 drive_current_d, wheel_goal_speed_a, wheel_goal_speed_b,
                 wheel_goal_speed_c, wheel_goal_speed_d, output ready);
endinterface

interface ocwc_csr_if import ocwc_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [31:0]          data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> sv/ocwc_div.sv
module ocwc_div import ocwc_pkg::*; #(
   parameter int DW = DEN_W,
   parameter int QW = QUOT_W
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [NUM_W-1:0] num,
   input  logic [DW-1:0]           den,
   output logic signed [QW-1:0]    quot
);

   localparam int RW = DW + 1;
   localparam logic signed [QW-1:0] QMAX = {1'b0, {(QW-1){1'b1}}};
   localparam logic signed [QW-1:0] QMIN = {1'b1, {(QW-1){1'b0}}};

   logic [NUM_W-1:0] mag_ff, mag_in;
   logic             neg_ff, neg_in, nz_ff, nz_in;

   logic [RW-1:0]     r_ff   [DIV_QB+1];
   logic [RW-1:0]     r_in   [DIV_QB+1];
   logic [DIV_QB-1:0] q_ff   [DIV_QB+1];
   logic [DIV_QB-1:0] q_in   [DIV_QB+1];
   logic [DIV_QB-1:0] lo_ff  [DIV_QB+1];
   logic [DIV_QB-1:0] lo_in  [DIV_QB+1];
   logic              sn_ff  [DIV_QB+1];
   logic              sn_in  [DIV_QB+1];
   logic              nzs_ff [DIV_QB+1];
   logic              nzs_in [DIV_QB+1];
   logic              ovf_ff [DIV_QB+1];
   logic              ovf_in [DIV_QB+1];

   logic signed [QW-1:0]     quot_ff, quot_in;
   logic signed [DIV_QB+1:0] sq;
   logic [NUM_W-DIV_QB-1:0]  hi;

   // take the magnitude and sign
   always_comb begin
      neg_in = num[NUM_W-1];
      nz_in  = (num != '0);
      mag_in = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
   end

   // quotient beyond 32 bits saturates; otherwise the upper half seeds the remainder
   always_comb begin
      hi        = mag_ff[NUM_W-1:DIV_QB];
      ovf_in[0] = (NUM_W'(hi) >= NUM_W'(den));
      r_in[0]   = RW'(hi);
      q_in[0]   = '0;
      lo_in[0]  = mag_ff[DIV_QB-1:0];
      sn_in[0]  = neg_ff;
      nzs_in[0] = nz_ff;
   end

   for (genvar s = 1; s <= DIV_QB; s++) begin : g_step
      logic [RW-1:0] t;
      logic          ge;
      always_comb begin
         t         = {r_ff[s-1][RW-2:0], lo_ff[s-1][DIV_QB-1]};
         ge        = (t >= {1'b0, den});
         r_in[s]   = ge ? (t - {1'b0, den}) : t;
         q_in[s]   = {q_ff[s-1][DIV_QB-2:0], ge};
         lo_in[s]  = {lo_ff[s-1][DIV_QB-2:0], 1'b0};
         sn_in[s]  = sn_ff[s-1];
         nzs_in[s] = nzs_ff[s-1];
         ovf_in[s] = ovf_ff[s-1];
      end
   end

   // apply sign, saturate to the output width
   always_comb begin
      sq = sn_ff[DIV_QB] ? -$signed({2'b00, q_ff[DIV_QB]}) : $signed({2'b00, q_ff[DIV_QB]});
      if (!nzs_ff[DIV_QB]) begin
         quot_in = '0;
      end else if (ovf_ff[DIV_QB]) begin
         quot_in = sn_ff[DIV_QB] ? QMIN : QMAX;
      end else if (sq > QMAX) begin
         quot_in = QMAX;
      end else if (sq < QMIN) begin
         quot_in = QMIN;
      end else begin
         quot_in = QW'(sq);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff  <= mag_in;
         neg_ff  <= neg_in;
         nz_ff   <= nz_in;
         quot_ff <= quot_in;
         for (int s = 0; s <= DIV_QB; s++) begin
            r_ff[s]   <= r_in[s];
            q_ff[s]   <= q_in[s];
            lo_ff[s]  <= lo_in[s];
            sn_ff[s]  <= sn_in[s];
            nzs_ff[s] <= nzs_in[s];
            ovf_ff[s] <= ovf_in[s];
         end
      end
   end

   assign quot = quot_ff;

endmodule

>>> sv/omni_chassis_wheel_current.sv
// An input transfer passes the capture, product and numerator stages, the restoring dividers,
// then the error, current-product, base-current and output stages before its result shows valid.
// Throughput: one item per cycle; the whole pipe advances whenever the output register is
// empty or its result is taken, so a stall holds every stage in place.
// Reset clears all valid bits and loads the register defaults; data stages are not reset.
module omni_chassis_wheel_current import ocwc_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input logic      clock,
   input logic      reset,
   ocwc_req_if.sink   req_bus,
   ocwc_rsp_if.source rsp_bus,
   ocwc_csr_if.sink   csr_bus
);

   localparam int CW  = FRAC_BITS + 1;
   localparam int PW  = 34 + CW;
   localparam int TOT = DIV_LAT + 7;
   // round-to-nearest geometry constants at FRAC_BITS fraction bits
   localparam logic [63:0] C_RAW = (COS45_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
   localparam logic [63:0] K_RAW = (RT8_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
   localparam logic signed [CW-1:0] C_Q = CW'(C_RAW);
   localparam logic signed [CW-1:0] K_Q = CW'(K_RAW);
   // wheel sign pattern of the 45-degree layout, bit i set where the term is negated
   localparam logic [WHEELS-1:0] SX_NEG = 4'b0011;
   localparam logic [WHEELS-1:0] SY_NEG = 4'b0110;

   typedef struct packed {
      logic signed [31:0] meas;
      logic signed [33:0] pkf;
   } side_type;

   // ---------------- configuration registers ----------------
   logic [DEN_W-1:0]   radius_ff, dist_ff, gain_ff, thr_ff;
   logic signed [31:0] fric_ff [WHEELS];

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RST;
         dist_ff   <= DIST_RST;
         gain_ff   <= GAIN_RST;
         thr_ff    <= THRESH_RST;
         for (int i = 0; i < WHEELS; i++) fric_ff[i] <= '0;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            REG_WHEEL_RADIUS:     radius_ff  <= csr_bus.data[DEN_W-1:0];
            REG_CENTER_DISTANCE:  dist_ff    <= csr_bus.data[DEN_W-1:0];
            REG_SPEED_ERROR_GAIN: gain_ff    <= csr_bus.data[DEN_W-1:0];
            REG_FRICTION_THRESH:  thr_ff     <= csr_bus.data[DEN_W-1:0];
            REG_FRICTION_A:       fric_ff[0] <= csr_bus.data;
            REG_FRICTION_B:       fric_ff[1] <= csr_bus.data;
            REG_FRICTION_C:       fric_ff[2] <= csr_bus.data;
            REG_FRICTION_D:       fric_ff[3] <= csr_bus.data;
            default: ;
         endcase
      end
   end

   // ---------------- pipe control ----------------
   // advance everything unless the output register holds a result nobody takes
   logic en;
   logic v_ff [TOT];
   logic v_in [TOT];

   assign en            = !v_ff[TOT-1] || rsp_bus.ready;
   assign req_bus.ready = en;
   assign rsp_bus.valid = v_ff[TOT-1];

   always_comb begin
      v_in[0] = req_bus.valid;
      for (int s = 1; s < TOT; s++) v_in[s] = v_ff[s-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < TOT; s++) v_ff[s] <= 1'b0;
      end else if (en) begin
         for (int s = 0; s < TOT; s++) v_ff[s] <= v_in[s];
      end
   end

   // ---------------- stage 0: capture the transfer ----------------
   logic signed [31:0] vx_ff, vy_ff, w_ff, fx_ff, fy_ff, tq_ff;
   logic signed [31:0] meas0_ff [WHEELS];
   logic signed [31:0] meas0_in [WHEELS];

   always_comb begin
      meas0_in[0] = req_bus.meas_speed_a;
      meas0_in[1] = req_bus.meas_speed_b;
      meas0_in[2] = req_bus.meas_speed_c;
      meas0_in[3] = req_bus.meas_speed_d;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vx_ff    <= req_bus.goal_vel_x;
         vy_ff    <= req_bus.goal_vel_y;
         w_ff     <= req_bus.goal_yaw_rate;
         fx_ff    <= req_bus.demand_force_x;
         fy_ff    <= req_bus.demand_force_y;
         tq_ff    <= req_bus.demand_torque;
         meas0_ff <= meas0_in;
      end
   end

   // ---------------- stage 1: products ----------------
   logic signed [PW-1:0] pc_ff [WHEELS], pc_in [WHEELS];
   logic signed [PW-1:0] pk_ff [WHEELS], pk_in [WHEELS];
   logic signed [63:0]   mf_ff [WHEELS], mf_in [WHEELS];
   logic signed [31:0]   meas1_ff [WHEELS];
   logic signed [63:0]   wd_ff, wd_in, tnum1_ff, tnum1_in;
   logic signed [33:0]   sl, sf;

   always_comb begin
      wd_in    = w_ff * $signed({1'b0, dist_ff});
      tnum1_in = 64'(tq_ff) <<< FRAC_BITS;
      for (int i = 0; i < WHEELS; i++) begin
         sl = (SY_NEG[i] ? -34'(vy_ff) : 34'(vy_ff)) + (SX_NEG[i] ? -34'(vx_ff) : 34'(vx_ff));
         sf = (SX_NEG[i] ? -34'(fx_ff) : 34'(fx_ff)) + (SY_NEG[i] ? -34'(fy_ff) : 34'(fy_ff));
         pc_in[i] = PW'(sl) * PW'(C_Q);
         pk_in[i] = PW'(sf) * PW'(K_Q);
         mf_in[i] = meas0_ff[i] * fric_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pc_ff    <= pc_in;
         pk_ff    <= pk_in;
         mf_ff    <= mf_in;
         wd_ff    <= wd_in;
         tnum1_ff <= tnum1_in;
         meas1_ff <= meas0_ff;
      end
   end

   // ---------------- stage 2: numerators ----------------
   logic signed [63:0] lin_ff [WHEELS], lin_in [WHEELS];
   logic signed [33:0] pkf_ff [WHEELS], pkf_in [WHEELS];
   logic signed [63:0] mf2_ff [WHEELS];
   logic signed [31:0] meas2_ff [WHEELS];
   logic signed [63:0] tnum2_ff;

   always_comb begin
      for (int i = 0; i < WHEELS; i++) begin
         lin_in[i] = -(64'(pc_ff[i]) + wd_ff);
         // arithmetic shift rounds the product toward minus infinity
         pkf_in[i] = 34'(pk_ff[i] >>> FRAC_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lin_ff   <= lin_in;
         pkf_ff   <= pkf_in;
         mf2_ff   <= mf_ff;
         meas2_ff <= meas1_ff;
         tnum2_ff <= tnum1_ff;
      end
   end

   // ---------------- dividers ----------------
   // the friction share keeps a full 32-bit quotient so the later sum saturates correctly
   logic signed [31:0]     goal_q [WHEELS];
   logic signed [FQ_W-1:0] fric_q [WHEELS];
   logic signed [31:0]     tsh_q;

   for (genvar i = 0; i < WHEELS; i++) begin : g_lane_div
      ocwc_div #(.DW(DEN_W), .QW(QUOT_W)) u_goal_div (
         .clock (clock),
         .en    (en),
         .num   (lin_ff[i]),
         .den   (radius_ff),
         .quot  (goal_q[i])
      );
      ocwc_div #(.DW(DEN_W), .QW(FQ_W)) u_fric_div (
         .clock (clock),
         .en    (en),
         .num   (mf2_ff[i]),
         .den   (thr_ff),
         .quot  (fric_q[i])
      );
   end

   // torque share: torque / (4 * center distance)
   ocwc_div #(.DW(TSH_DEN_W), .QW(QUOT_W)) u_tsh_div (
      .clock (clock),
      .en    (en),
      .num   (tnum2_ff),
      .den   ({dist_ff, 2'b00}),
      .quot  (tsh_q)
   );

   // hold measured speed and force share alongside the dividers
   side_type side_ff [DIV_LAT][WHEELS];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < WHEELS; i++) begin
            side_ff[0][i] <= '{meas: meas2_ff[i], pkf: pkf_ff[i]};
         end
         for (int s = 1; s < DIV_LAT; s++) side_ff[s] <= side_ff[s-1];
      end
   end

   // ---------------- stage 3: force and speed error ----------------
   logic signed [31:0]     force_ff [WHEELS], force_in [WHEELS];
   logic signed [31:0]     diff_ff [WHEELS], diff_in [WHEELS];
   logic signed [31:0]     goal3_ff [WHEELS];
   logic signed [FQ_W-1:0] fq3_ff [WHEELS];

   always_comb begin
      for (int i = 0; i < WHEELS; i++) begin
         force_in[i] = sat32(65'(side_ff[DIV_LAT-1][i].pkf) + 65'(tsh_q));
         diff_in[i]  = sat32(65'(goal_q[i]) - 65'(side_ff[DIV_LAT-1][i].meas));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         force_ff <= force_in;
         diff_ff  <= diff_in;
         goal3_ff <= goal_q;
         fq3_ff   <= fric_q;
      end
   end

   // ---------------- stage 4: current products ----------------
   logic signed [63:0]     fr_ff [WHEELS], fr_in [WHEELS];
   logic signed [63:0]     gd_ff [WHEELS], gd_in [WHEELS];
   logic signed [31:0]     goal4_ff [WHEELS];
   logic signed [FQ_W-1:0] fq4_ff [WHEELS];

   always_comb begin
      for (int i = 0; i < WHEELS; i++) begin
         fr_in[i] = force_ff[i] * $signed({1'b0, radius_ff});
         gd_in[i] = diff_ff[i] * $signed({1'b0, gain_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fr_ff    <= fr_in;
         gd_ff    <= gd_in;
         goal4_ff <= goal3_ff;
         fq4_ff   <= fq3_ff;
      end
   end

   // ---------------- stage 5: base current ----------------
   logic signed [31:0]     cur_ff [WHEELS], cur_in [WHEELS];
   logic signed [31:0]     goal5_ff [WHEELS];
   logic signed [FQ_W-1:0] fq5_ff [WHEELS];

   always_comb begin
      for (int i = 0; i < WHEELS; i++) begin
         cur_in[i] = sat32(65'((gd_ff[i] - fr_ff[i]) >>> FRAC_BITS));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cur_ff   <= cur_in;
         goal5_ff <= goal4_ff;
         fq5_ff   <= fq4_ff;
      end
   end

   // ---------------- stage 6: friction feedforward, output register ----------------
   logic signed [31:0] out_cur_ff [WHEELS], out_cur_in [WHEELS];
   logic signed [31:0] out_goal_ff [WHEELS];
   logic signed [32:0] thr_s;

   always_comb begin
      thr_s = $signed({2'b00, thr_ff});
      for (int i = 0; i < WHEELS; i++) begin
         if (33'(goal5_ff[i]) > thr_s) begin
            out_cur_in[i] = sat32(65'(cur_ff[i]) + 65'(fric_ff[i]));
         end else if (33'(goal5_ff[i]) < -thr_s) begin
            out_cur_in[i] = sat32(65'(cur_ff[i]) - 65'(fric_ff[i]));
         end else if (thr_ff != '0) begin
            // inside the deadband: share proportional to measured speed
            out_cur_in[i] = sat32(65'(cur_ff[i]) + 65'(fq5_ff[i]));
         end else begin
            out_cur_in[i] = cur_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_cur_ff  <= out_cur_in;
         out_goal_ff <= goal5_ff;
      end
   end

   assign rsp_bus.drive_current_a    = out_cur_ff[0];
   assign rsp_bus.drive_current_b    = out_cur_ff[1];
   assign rsp_bus.drive_current_c    = out_cur_ff[2];
   assign rsp_bus.drive_current_d    = out_cur_ff[3];
   assign rsp_bus.wheel_goal_speed_a = out_goal_ff[0];
   assign rsp_bus.wheel_goal_speed_b = out_goal_ff[1];
   assign rsp_bus.wheel_goal_speed_c = out_goal_ff[2];
   assign rsp_bus.wheel_goal_speed_d = out_goal_ff[3];

endmodule

>>> sim/omni_chassis_wheel_current_tb.sv
module omni_chassis_wheel_current_tb;
   import ocwc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FB       = FRAC_BITS_DEF;
   localparam int LATENCY  = DIV_LAT + 7;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic signed [31:0] vx, vy, yaw, fx, fy, tq;
      logic signed [31:0] ms_a, ms_b, ms_c, ms_d;
   } chassis_cmd_type;

   typedef struct packed {
      logic signed [31:0] cur_a, cur_b, cur_c, cur_d;
      logic signed [31:0] spd_a, spd_b, spd_c, spd_d;
   } wheel_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ocwc_req_if req_bus ();
   ocwc_rsp_if rsp_bus ();
   ocwc_csr_if csr_bus ();

   omni_chassis_wheel_current DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source),
      .csr_bus (csr_bus.sink)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the chassis registers.
   logic [30:0]        radius_q, dist_q, gain_q, thresh_q;
   logic signed [31:0] fric_q [WHEELS];

   chassis_cmd_type cmd_queue [$];
   wheel_out_type   expected_wheels [$];

   int errors = 0;
   int cycles = 0;
   int sent = 0;
   int checked = 0;
   bit hold_off = 1'b0;
   bit csr_busy = 1'b0;

   // Signed 128-bit helpers; all products here fit comfortably in 128 bits.
   function automatic logic signed [127:0] clamp32(input logic signed [127:0] v);
      if (v > 128'sd2147483647) return 128'sd2147483647;
      if (v < -128'sd2147483648) return -128'sd2147483648;
      return v;
   endfunction

   function automatic logic signed [127:0] quot_trunc(input logic signed [127:0] num,
                                                        input logic signed [127:0] den);
      if (den == 0) begin
         if (num > 0) return 128'sd2147483647;
         if (num < 0) return -128'sd2147483648;
         return 0;
      end
      return clamp32(num / den);
   endfunction

   // Arithmetic shift is floor for two's complement.
   function automatic logic signed [127:0] floor_frac(input logic signed [127:0] v);
      return v >>> FB;
   endfunction

   function automatic wheel_out_type predict_wheels(input chassis_cmd_type c);
      logic signed [127:0] cos45, rt8, tshare, lin, goal, force_w, diff, cur, meas, fric;
      logic signed [127:0] r, d, g, th;
      logic signed [31:0]  goals [WHEELS];
      logic signed [31:0]  curs  [WHEELS];
      int sx, sy;
      wheel_out_type o;
      cos45 = 128'((COS45_Q32 + (64'd1 << (31 - FB))) >> (32 - FB));
      rt8   = 128'((RT8_Q32 + (64'd1 << (31 - FB))) >> (32 - FB));
      r = 128'(radius_q); d = 128'(dist_q); g = 128'(gain_q); th = 128'(thresh_q);
      tshare = quot_trunc(128'(c.tq) * (128'sd1 <<< FB), 4 * d);
      for (int i = 0; i < WHEELS; i++) begin
         sx = (i < 2) ? -1 : 1;
         sy = (i == 0 || i == 3) ? 1 : -1;
         case (i)
            0: meas = c.ms_a;
            1: meas = c.ms_b;
            2: meas = c.ms_c;
            default: meas = c.ms_d;
         endcase
         fric = fric_q[i];
         lin = -(cos45 * (sy * 128'(c.vy) + sx * 128'(c.vx)) + 128'(c.yaw) * d);
         goal = quot_trunc(lin, r);
         force_w = clamp32(floor_frac(rt8 * (sx * 128'(c.fx) + sy * 128'(c.fy))) + tshare);
         diff = clamp32(goal - meas);
         cur = clamp32(floor_frac(-(force_w * r) + g * diff));
         if (goal > th) cur = clamp32(cur + fric);
         else if (goal < -th) cur = clamp32(cur - fric);
         else if (th != 0) cur = clamp32(cur + (meas * fric) / th);
         goals[i] = goal[31:0];
         curs[i] = cur[31:0];
      end
      o.cur_a = curs[0]; o.cur_b = curs[1]; o.cur_c = curs[2]; o.cur_d = curs[3];
      o.spd_a = goals[0]; o.spd_b = goals[1]; o.spd_c = goals[2]; o.spd_d = goals[3];
      return o;
   endfunction

   // Driver: bursts of transfers separated by random gaps.
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (req_bus.valid) begin
            expected_wheels.push_back(predict_wheels(cmd_queue.pop_front()));
            sent++;
         end
         if (gap_left > 0) begin
            gap_left--;
            req_bus.valid <= 1'b0;
         end else if (cmd_queue.size() > 0 && !csr_busy) begin
            {req_bus.goal_vel_x, req_bus.goal_vel_y, req_bus.goal_yaw_rate,
             req_bus.demand_force_x, req_bus.demand_force_y, req_bus.demand_torque,
             req_bus.meas_speed_a, req_bus.meas_speed_b, req_bus.meas_speed_c,
             req_bus.meas_speed_d} <= cmd_queue[0];
            req_bus.valid <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 20);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            end
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Receiver stalls on its own pattern; hold_off forces a long stretch.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= !hold_off && ($urandom_range(0, 3) != 0 || cycles[9]);
      end
   end

   // Monitor: compare each result transfer against the oldest expectation.
   always @(posedge clock) begin
      wheel_out_type exp_w, got;
      cycles++;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = {rsp_bus.drive_current_a, rsp_bus.drive_current_b, rsp_bus.drive_current_c,
                rsp_bus.drive_current_d, rsp_bus.wheel_goal_speed_a,
                rsp_bus.wheel_goal_speed_b, rsp_bus.wheel_goal_speed_c,
                rsp_bus.wheel_goal_speed_d};
         if (expected_wheels.size() == 0) begin
            $error("result transfer with nothing expected");
            errors++;
         end else begin
            exp_w = expected_wheels.pop_front();
            checked++;
            if (got.cur_a !== exp_w.cur_a) begin
               $error("drive_current_a exp %0d got %0d", exp_w.cur_a, got.cur_a); errors++;
            end
            if (got.cur_b !== exp_w.cur_b) begin
               $error("drive_current_b exp %0d got %0d", exp_w.cur_b, got.cur_b); errors++;
            end
            if (got.cur_c !== exp_w.cur_c) begin
               $error("drive_current_c exp %0d got %0d", exp_w.cur_c, got.cur_c); errors++;
            end
            if (got.cur_d !== exp_w.cur_d) begin
               $error("drive_current_d exp %0d got %0d", exp_w.cur_d, got.cur_d); errors++;
            end
            if (got.spd_a !== exp_w.spd_a) begin
               $error("wheel_goal_speed_a exp %0d got %0d", exp_w.spd_a, got.spd_a);
               errors++;
            end
            if (got.spd_b !== exp_w.spd_b) begin
               $error("wheel_goal_speed_b exp %0d got %0d", exp_w.spd_b, got.spd_b);
               errors++;
            end
            if (got.spd_c !== exp_w.spd_c) begin
               $error("wheel_goal_speed_c exp %0d got %0d", exp_w.spd_c, got.spd_c);
               errors++;
            end
            if (got.spd_d !== exp_w.spd_d) begin
               $error("wheel_goal_speed_d exp %0d got %0d", exp_w.spd_d, got.spd_d);
               errors++;
            end
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("== FAIL ==");
         $finish;
      end
   end

   // Drive a register write transfer, then mirror it into the shadow copy.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      case (idx)
         REG_WHEEL_RADIUS:     radius_q = val[30:0];
         REG_CENTER_DISTANCE:  dist_q = val[30:0];
         REG_SPEED_ERROR_GAIN: gain_q = val[30:0];
         REG_FRICTION_THRESH:  thresh_q = val[30:0];
         REG_FRICTION_A:       fric_q[0] = val;
         REG_FRICTION_B:       fric_q[1] = val;
         REG_FRICTION_C:       fric_q[2] = val;
         default:              fric_q[3] = val;
      endcase
   endtask

   // Wait until every expectation has drained and the pipe is empty.
   task automatic drain_pipe();
      while (!(cmd_queue.size() == 0 && !req_bus.valid && expected_wheels.size() == 0))
         @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'(signed'($urandom_range(0, 131072)) - 65536);
         3: return 32'($urandom_range(0, 2)) - 1;
         4: return 32'(signed'($urandom_range(0, 2097152)) - 1048576);
         default: return $urandom;
      endcase
   endfunction

   function automatic chassis_cmd_type rand_cmd();
      chassis_cmd_type c;
      c = {rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
           rand_word(), rand_word(), rand_word(), rand_word(), rand_word()};
      return c;
   endfunction

   task automatic load_random(input int n);
      for (int i = 0; i < n; i++) cmd_queue.push_back(rand_cmd());
   endtask

   task automatic write_all(input logic [31:0] r, input logic [31:0] d,
                            input logic [31:0] g, input logic [31:0] th);
      write_reg(REG_WHEEL_RADIUS, r);
      write_reg(REG_CENTER_DISTANCE, d);
      write_reg(REG_SPEED_ERROR_GAIN, g);
      write_reg(REG_FRICTION_THRESH, th);
      write_reg(REG_FRICTION_A, rand_word());
      write_reg(REG_FRICTION_B, rand_word());
      write_reg(REG_FRICTION_C, rand_word());
      write_reg(REG_FRICTION_D, rand_word());
   endtask

   initial begin
      chassis_cmd_type c;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data  = '0;
      req_bus.valid = 1'b0;
      {req_bus.goal_vel_x, req_bus.goal_vel_y, req_bus.goal_yaw_rate,
       req_bus.demand_force_x, req_bus.demand_force_y, req_bus.demand_torque,
       req_bus.meas_speed_a, req_bus.meas_speed_b, req_bus.meas_speed_c,
       req_bus.meas_speed_d} = '0;
      rsp_bus.ready = 1'b0;
      radius_q = RADIUS_RST; dist_q = DIST_RST; gain_q = GAIN_RST; thresh_q = THRESH_RST;
      for (int i = 0; i < WHEELS; i++) fric_q[i] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero, field extremes, deadband edges, under reset defaults.
      cmd_queue.push_back('0);
      cmd_queue.push_back({10{32'h7fffffff}});
      cmd_queue.push_back({10{32'h80000000}});
      cmd_queue.push_back({32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                           32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                           32'h7fffffff, 32'h80000000});
      cmd_queue.push_back({32'h00010000, 32'h0, 32'h0, 32'h00010000, 32'h0, 32'h00010000,
                           32'hffff0000, 32'h00010000, 32'h0, 32'h7fffffff});
      drain_pipe();

      // Extreme register settings: small radius, large gain, zero threshold.
      write_all(32'd1, 32'd1, 32'h7fffffff, 32'd0);
      cmd_queue.push_back('0);
      cmd_queue.push_back({10{32'h7fffffff}});
      cmd_queue.push_back({10{32'h80000000}});
      load_random(8);
      drain_pipe();

      // Zero radius, distance and threshold (degenerate divisions).
      write_all(32'd0, 32'd0, 32'd65536, 32'd0);
      cmd_queue.push_back('0);
      cmd_queue.push_back({32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h00010000,
                           32'h0, 32'h0, 32'h0, 32'h0});
      cmd_queue.push_back({32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'hffff0000,
                           32'h0, 32'h0, 32'h0, 32'h0});
      load_random(6);
      drain_pipe();

      // Large radius/distance/threshold; all extremes around deadband.
      write_all(32'hffffffff, 32'hffffffff, 32'd0, 32'hffffffff);
      load_random(10);
      drain_pipe();

      // Random phases with realistic settings and small inputs near the deadband.
      for (int ph = 0; ph < 6; ph++) begin
         write_all($urandom_range(1000, 200000), $urandom_range(1000, 200000),
                   $urandom_range(0, 300000), $urandom_range(1, 100000));
         for (int i = 0; i < 90; i++) begin
            c = rand_cmd();
            if ($urandom_range(0, 2) == 0) begin
               c.vx = 32'(signed'($urandom_range(0, 4000)) - 2000);
               c.vy = 32'(signed'($urandom_range(0, 4000)) - 2000);
               c.yaw = 32'(signed'($urandom_range(0, 4000)) - 2000);
            end
            cmd_queue.push_back(c);
         end
         if (ph == 2) begin
            // Hold the receiver off so the pipe fills and back-pressures the input.
            hold_off = 1'b1;
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end
         drain_pipe();
      end

      $display("sent %0d commands, checked %0d results over 10 register settings",
               sent, checked);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
